/* src/chgs_pkg.sv */
// ----------------------------------------------------------------------------
// chgs_pkg: shared types and constants of the convex hull graham scan unit
// Point width, cell record, stack operations, angle classes and controller
// states used across the cell chains and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package chgs_pkg;

    localparam int POINTS      = 32;
    localparam int COORD_BITS  = 16;
    localparam int IDX_W       = $clog2(POINTS);
    localparam int CNT_W       = $clog2(POINTS + 1);
    localparam int DIFF_W      = COORD_BITS + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int SQ_W        = PROD_W + 1;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 40;
    localparam int HCNT_W      = 6;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic [IDX_W-1:0]             idx;
        logic                         valid;
        logic                         used;
    } point_cell_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } stack_pt_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } ring_ctrl_t;

    typedef enum logic [1:0] {
        STK_HOLD,
        STK_DOWN,
        STK_UP
    } stk_op_t;

    typedef enum logic [1:0] {
        CLS_RIGHT,
        CLS_UPPER,
        CLS_LEFT
    } ang_cls_t;

    typedef enum logic [3:0] {
        S_LOAD,
        S_PIVOT,
        S_ECHO,
        S_SEL_MUL,
        S_SEL_CMP,
        S_SEL_END,
        S_SCAN_TEST,
        S_SCAN_MUL,
        S_SCAN_DEC,
        S_ALIGN,
        S_EMIT
    } state_t;

    // polar class about the pivot: level and right, upper half, level and left
    function automatic ang_cls_t ang_class(input logic signed [DIFF_W-1:0] rx,
                                           input logic signed [DIFF_W-1:0] ry);
        ang_cls_t c;
        if (ry == '0 && !rx[DIFF_W-1]) begin
            c = CLS_RIGHT;
        end else if (!ry[DIFF_W-1] && ry != '0) begin
            c = CLS_UPPER;
        end else begin
            c = CLS_LEFT;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* src/chgs_point_cell.sv */
// ----------------------------------------------------------------------------
// chgs_point_cell: one cell of the point ring
// Holds one stored point with its arrival index and flags; takes its
// neighbour's record on every shift, drops its valid flag on clear.
// ----------------------------------------------------------------------------
`default_nettype none

module chgs_point_cell
    import chgs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire ring_ctrl_t  ctrl,
    input  wire point_cell_t d,
    output point_cell_t      q
);

    point_cell_t data_reg;
    logic        valid_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            data_reg <= d;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            valid_reg <= 1'b0;
        end else if (ctrl.shift) begin
            valid_reg <= d.valid;
        end
    end

    always_comb begin
        q       = data_reg;
        q.valid = valid_reg;
    end

endmodule

`default_nettype wire

/* src/chgs_stack_cell.sv */
// ----------------------------------------------------------------------------
// chgs_stack_cell: one cell of the hull stack
// Push and drain move points one cell deeper, pop moves them one cell up.
// ----------------------------------------------------------------------------
`default_nettype none

module chgs_stack_cell
    import chgs_pkg::*;
(
    input  wire logic      aclk,
    input  wire stk_op_t   op,
    input  wire stack_pt_t from_up,
    input  wire stack_pt_t from_down,
    output stack_pt_t      q
);

    stack_pt_t pt_reg;

    always_ff @(posedge aclk) begin
        case (op)
            STK_DOWN: pt_reg <= from_up;
            STK_UP:   pt_reg <= from_down;
            default:  pt_reg <= pt_reg;
        endcase
    end

    assign q = pt_reg;

endmodule

`default_nettype wire

/* src/convex_hull_graham_scan_unit.sv */
// ----------------------------------------------------------------------------
// convex_hull_graham_scan_unit: convex hull of a point set by graham scan
// Input stream: one point per transaction, tlast marks the last point of a
// set. Up to 32 points are kept in a ring of cells; further points are
// dropped and reported through m_tuser on every vertex of that set.
// After the last point the ring rotates once to find the pivot, then each
// pass rotates the ring through one shared angle comparator to pick the
// next point in polar order, which feeds the scan; each pop repeats the
// turn test. The run time of a full set of 32 points is set by the single
// comparator walking the ring once per point. Sets of one or two points
// are echoed after one rotation.
// Output stream: hull vertices counter-clockwise from the pivot, tlast on
// the final one, hull size in tdata. The stack is first shifted so that its
// bottom reaches the exit cell, then one vertex leaves per transaction.
// The output register lets emission stall on m_tready without loss; input
// is taken only while loading a set.
// Reset (aresetn low, synchronous) empties the ring and the stack and
// returns to loading.
// ----------------------------------------------------------------------------
`default_nettype none

module convex_hull_graham_scan_unit
    import chgs_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // point_x, point_y
    input  wire logic                   s_tlast,   // last_point
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,   // hull_x, hull_y, hull_count, zero pad
    output logic                        m_tlast,   // last_vertex
    output logic [0:0]                  m_tuser    // overflow
);

    state_t state_reg, state_next;

    point_cell_t pc_q [POINTS];
    point_cell_t pc_d [POINTS];
    ring_ctrl_t  ring_ctrl;
    point_cell_t head, head_marked, new_pt;
    logic        ring_load;

    stack_pt_t   sk_q [POINTS];
    stk_op_t     stk_op;
    stack_pt_t   stk_in;
    logic        stk_push;

    logic [CNT_W-1:0] cnt_reg, sp_reg, pos_reg, em_reg;
    logic             drop_reg;
    logic [IDX_W-1:0] rot_reg;
    logic             rot_last, not_full;

    logic signed [COORD_BITS-1:0] piv_x_reg, piv_y_reg;
    logic                         piv_have_reg;

    logic signed [COORD_BITS-1:0] bx_reg, by_reg;
    logic signed [DIFF_W-1:0]     brx_reg, bry_reg;
    logic [SQ_W-1:0]              bd_reg;
    ang_cls_t                     bcls_reg;
    logic [IDX_W-1:0]             bidx_reg, prev_idx_reg;
    logic                         found_reg, prev_vld_reg;

    logic signed [PROD_W-1:0] ml_reg, mr_reg, p1_reg, p2_reg;
    logic [PROD_W-1:0]        msx_reg, msy_reg;
    ang_cls_t                 mcls_reg;

    logic signed [DIFF_W-1:0] hrx, hry, d1x, d1y, d2x, d2y;
    logic [SQ_W-1:0]          dh;
    logic                     cand, precedes, v_eq_top, out_free;

    logic                         m_tvalid_reg, olast_reg, oovf_reg;
    logic signed [COORD_BITS-1:0] ox_reg, oy_reg;
    logic [CNT_W-1:0]             ocnt_reg;

    // ring of point cells, head at the far end
    assign head     = pc_q[POINTS-1];
    assign rot_last = (rot_reg == IDX_W'(POINTS - 1));
    assign not_full = (cnt_reg < CNT_W'(POINTS));

    always_comb begin
        new_pt.x     = s_tdata[COORD_BITS-1:0];
        new_pt.y     = s_tdata[2*COORD_BITS-1:COORD_BITS];
        new_pt.idx   = cnt_reg[IDX_W-1:0];
        new_pt.valid = 1'b1;
        new_pt.used  = 1'b0;
        head_marked  = head;
        if (prev_vld_reg && head.idx == prev_idx_reg) begin
            head_marked.used = 1'b1;
        end
        pc_d[0] = ring_load ? new_pt : head_marked;
        for (int k = 1; k < POINTS; k++) begin
            pc_d[k] = pc_q[k-1];
        end
    end

    for (genvar g = 0; g < POINTS; g++) begin : g_ring
        chgs_point_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ring_ctrl),
            .d       (pc_d[g]),
            .q       (pc_q[g])
        );
    end

    for (genvar g = 0; g < POINTS; g++) begin : g_stack
        stack_pt_t up_in, down_in;
        if (g == 0) begin : g_top
            assign up_in = stk_in;
        end else begin : g_mid
            assign up_in = sk_q[g-1];
        end
        if (g == POINTS - 1) begin : g_bot
            assign down_in = '0;
        end else begin : g_up
            assign down_in = sk_q[g+1];
        end
        chgs_stack_cell u_cell (
            .aclk      (aclk),
            .op        (stk_op),
            .from_up   (up_in),
            .from_down (down_in),
            .q         (sk_q[g])
        );
    end

    // comparator inputs
    assign hrx = DIFF_W'(head.x) - DIFF_W'(piv_x_reg);
    assign hry = DIFF_W'(head.y) - DIFF_W'(piv_y_reg);
    assign dh  = SQ_W'(msx_reg) + SQ_W'(msy_reg);
    assign cand = head.valid && !head.used && !(prev_vld_reg && head.idx == prev_idx_reg);

    always_comb begin
        if (!found_reg) begin
            precedes = 1'b1;
        end else if (mcls_reg != bcls_reg) begin
            precedes = (mcls_reg < bcls_reg);
        end else if (mcls_reg == CLS_UPPER && ml_reg != mr_reg) begin
            precedes = (ml_reg > mr_reg);
        end else begin
            precedes = (dh < bd_reg);
        end
    end

    // scan turn test: top-second then best-top
    assign d1x = DIFF_W'(sk_q[0].x) - DIFF_W'(sk_q[1].x);
    assign d1y = DIFF_W'(sk_q[0].y) - DIFF_W'(sk_q[1].y);
    assign d2x = DIFF_W'(bx_reg) - DIFF_W'(sk_q[0].x);
    assign d2y = DIFF_W'(by_reg) - DIFF_W'(sk_q[0].y);
    assign v_eq_top = (bx_reg == sk_q[0].x) && (by_reg == sk_q[0].y);

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        ring_ctrl.shift = 1'b0;
        ring_ctrl.clear = 1'b0;
        ring_load       = 1'b0;
        stk_op          = STK_HOLD;
        stk_push        = 1'b0;
        stk_in.x        = bx_reg;
        stk_in.y        = by_reg;
        s_tready        = 1'b0;
        case (state_reg)
            S_LOAD: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (not_full) begin
                        ring_ctrl.shift = 1'b1;
                        ring_load       = 1'b1;
                    end
                    if (s_tlast) begin
                        if ((cnt_reg + CNT_W'(not_full)) < CNT_W'(3)) begin
                            state_next = S_ECHO;
                        end else begin
                            state_next = S_PIVOT;
                        end
                    end
                end
            end
            S_PIVOT: begin
                ring_ctrl.shift = 1'b1;
                if (rot_last) begin
                    state_next = S_SEL_MUL;
                end
            end
            S_ECHO: begin
                ring_ctrl.shift = 1'b1;
                if (head.valid) begin
                    stk_op   = STK_DOWN;
                    stk_push = 1'b1;
                    stk_in.x = head.x;
                    stk_in.y = head.y;
                end
                if (rot_last) begin
                    state_next = S_ALIGN;
                end
            end
            S_SEL_MUL: begin
                state_next = S_SEL_CMP;
            end
            S_SEL_CMP: begin
                ring_ctrl.shift = 1'b1;
                state_next      = rot_last ? S_SEL_END : S_SEL_MUL;
            end
            S_SEL_END: begin
                if (!found_reg) begin
                    state_next = S_ALIGN;
                end else if (sp_reg != '0 && v_eq_top) begin
                    state_next = S_SEL_MUL;
                end else begin
                    state_next = S_SCAN_TEST;
                end
            end
            S_SCAN_TEST: begin
                if (sp_reg >= CNT_W'(2)) begin
                    state_next = S_SCAN_MUL;
                end else begin
                    stk_op     = STK_DOWN;
                    stk_push   = 1'b1;
                    state_next = S_SEL_MUL;
                end
            end
            S_SCAN_MUL: begin
                state_next = S_SCAN_DEC;
            end
            S_SCAN_DEC: begin
                if (p1_reg <= p2_reg) begin
                    stk_op     = STK_UP;
                    state_next = S_SCAN_TEST;
                end else begin
                    stk_op     = STK_DOWN;
                    stk_push   = 1'b1;
                    state_next = S_SEL_MUL;
                end
            end
            S_ALIGN: begin
                if ((CNT_W'(1) + CNT_W'(0) == CNT_W'(1)) &&
                    ({1'b0, pos_reg} + {1'b0, sp_reg} == (CNT_W+1)'(POINTS))) begin
                    state_next = S_EMIT;
                end else begin
                    stk_op = STK_DOWN;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    stk_op = STK_DOWN;
                    if (em_reg == sp_reg - CNT_W'(1)) begin
                        ring_ctrl.clear = 1'b1;
                        state_next      = S_LOAD;
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    // control counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            drop_reg     <= 1'b0;
            rot_reg      <= '0;
            sp_reg       <= '0;
            pos_reg      <= '0;
            em_reg       <= '0;
            piv_have_reg <= 1'b0;
            found_reg    <= 1'b0;
            prev_vld_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (state_reg == S_LOAD && s_tvalid) begin
                if (not_full) begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end else begin
                    drop_reg <= 1'b1;
                end
                if (s_tlast) begin
                    rot_reg      <= '0;
                    sp_reg       <= '0;
                    pos_reg      <= '0;
                    em_reg       <= '0;
                    piv_have_reg <= 1'b0;
                    found_reg    <= 1'b0;
                    prev_vld_reg <= 1'b0;
                end
            end
            if (ring_ctrl.shift && !ring_load) begin
                rot_reg <= rot_last ? '0 : rot_reg + IDX_W'(1);
            end
            if (state_reg == S_PIVOT && head.valid &&
                (!piv_have_reg || head.y < piv_y_reg)) begin
                piv_have_reg <= 1'b1;
            end
            if (state_reg == S_SEL_CMP && cand && precedes) begin
                found_reg <= 1'b1;
            end
            if (state_reg == S_SEL_END) begin
                found_reg <= 1'b0;
                if (found_reg) begin
                    prev_vld_reg <= 1'b1;
                end
            end
            if (stk_push) begin
                sp_reg <= sp_reg + CNT_W'(1);
            end else if (stk_op == STK_UP) begin
                sp_reg <= sp_reg - CNT_W'(1);
            end
            if (state_reg == S_ALIGN && stk_op == STK_DOWN) begin
                pos_reg <= pos_reg + CNT_W'(1);
            end
            if (state_reg == S_EMIT && out_free) begin
                m_tvalid_reg <= 1'b1;
                em_reg       <= em_reg + CNT_W'(1);
                if (state_next == S_LOAD) begin
                    cnt_reg  <= '0;
                    drop_reg <= 1'b0;
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (state_reg == S_PIVOT && head.valid && (!piv_have_reg || head.y < piv_y_reg)) begin
            piv_x_reg <= head.x;
            piv_y_reg <= head.y;
        end
        if (state_reg == S_SEL_MUL) begin
            ml_reg   <= hrx * bry_reg;
            mr_reg   <= hry * brx_reg;
            msx_reg  <= $unsigned(PROD_W'(hrx) * PROD_W'(hrx));
            msy_reg  <= $unsigned(PROD_W'(hry) * PROD_W'(hry));
            mcls_reg <= ang_class(hrx, hry);
        end
        if (state_reg == S_SEL_CMP && cand && precedes) begin
            bx_reg   <= head.x;
            by_reg   <= head.y;
            brx_reg  <= hrx;
            bry_reg  <= hry;
            bd_reg   <= dh;
            bcls_reg <= mcls_reg;
            bidx_reg <= head.idx;
        end
        if (state_reg == S_SEL_END && found_reg) begin
            prev_idx_reg <= bidx_reg;
        end
        if (state_reg == S_SCAN_MUL) begin
            p1_reg <= d1x * d2y;
            p2_reg <= d1y * d2x;
        end
        if (state_reg == S_EMIT && out_free) begin
            ox_reg    <= sk_q[POINTS-1].x;
            oy_reg    <= sk_q[POINTS-1].y;
            ocnt_reg  <= sp_reg;
            olast_reg <= (em_reg == sp_reg - CNT_W'(1));
            oovf_reg  <= drop_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - 2*COORD_BITS - HCNT_W){1'b0}},
                       HCNT_W'(ocnt_reg), oy_reg, ox_reg};
    assign m_tlast  = olast_reg;
    assign m_tuser  = oovf_reg;

endmodule

`default_nettype wire
